/* rtl/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion helpers shared by the RTL. Every check is sampled on clk and is
// disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication
`define CTH_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define CTH_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/cth_pkg.sv */
// ----------------------------------------------------------------------------
// cth_pkg
// Shared types, sizes and codes for the color threshold centroid block.
// ----------------------------------------------------------------------------
`default_nettype none

package cth_pkg;

    // Frame geometry limits
    localparam int MAX_WIDTH  = 2048;
    localparam int MAX_HEIGHT = 2048;

    localparam int COL_W = (MAX_WIDTH  > 1) ? $clog2(MAX_WIDTH)  : 1;
    localparam int ROW_W = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;

    // Hit counter and its saturation limit
    localparam int CNT_W           = 23;
    localparam int COUNT_FIELD_MAX = (2 ** CNT_W) - 1;
    localparam int FRAME_AREA      = MAX_WIDTH * MAX_HEIGHT;
    localparam int COUNT_LIMIT     = (FRAME_AREA < COUNT_FIELD_MAX) ? FRAME_AREA
                                                                    : COUNT_FIELD_MAX;

    // Divider sizes: the mean never exceeds the largest coordinate
    localparam int QUO_W  = (COL_W > ROW_W) ? COL_W : ROW_W;
    localparam int SUM_W  = QUO_W + CNT_W;
    localparam int STEP_W = $clog2(QUO_W + 1);

    // Field widths
    localparam int PIX_W   = 8;
    localparam int PAINT_W = 24;
    localparam int CENT_W  = 12;

    // Configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;
    localparam int MODE_W     = 2;

    localparam logic [CFG_IDX_W-1:0] REG_MODE     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CH1_LOW  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CH1_HIGH = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CH2_LOW  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_CH2_HIGH = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_CH3_LOW  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_CH3_HIGH = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_PAINT    = 3'd7;

    // Match modes
    localparam logic [MODE_W-1:0] MODE_BGR  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_HSV  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_GRAY = 2'd2;

    localparam logic [PIX_W-1:0] HUE_TOP = 8'd180;
    localparam logic [PIX_W-1:0] MASK_ON = 8'd255;

    // Pixel transaction
    typedef struct packed {
        logic [PIX_W-1:0] chan1;
        logic [PIX_W-1:0] chan2;
        logic [PIX_W-1:0] chan3;
        logic             end_of_line;
        logic             end_of_frame;
    } cth_pix_t;

    // Result transaction
    typedef struct packed {
        logic [PIX_W-1:0]          mask;
        logic                      hit;
        logic [PAINT_W-1:0]        paint_out;
        logic                      frame_done;
        logic [CNT_W-1:0]          hit_total;
        logic signed [CENT_W-1:0]  centroid_x;
        logic signed [CENT_W-1:0]  centroid_y;
    } cth_res_t;

    // Controller to datapath commands
    typedef struct packed {
        logic accept;
        logic load_pixel;
        logic start_div;
        logic div_step;
        logic load_frame;
    } cth_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic div_last;
    } cth_stat_t;

endpackage

`default_nettype wire

/* rtl/color_threshold_centroid.sv */
// ----------------------------------------------------------------------------
// color_threshold_centroid
// Color range segmentation: per-pixel mask and paint, per-frame hit count
// and hit centroid.
//
//   channel  | direction | handshake            | payload
//   ---------+-----------+----------------------+-----------------------
//   pix      | in        | pix_valid/pix_stall  | cth_pix_t
//   res      | out       | res_valid/res_stall  | cth_res_t
//   cfg      | in        | cfg_we               | cfg_index, cfg_data
//
// An ordinary pixel's result is registered, and the next pixel is taken
// while that result is drained.
// An end-of-frame pixel starts the restoring divider, which yields one
// quotient bit per cycle for both axes at once; then the frame result is loaded.
// Reset loads the default ranges and clears position and accumulators; there
// is no clearing pass. A stalled result holds the pixel side off.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module color_threshold_centroid
    import cth_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  pix_valid,
    output logic                       pix_stall,
    input  wire cth_pix_t              pix,
    output logic                       res_valid,
    input  wire logic                  res_stall,
    output cth_res_t                   res,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    cth_cmd_t  cmd;
    cth_stat_t stat;

    cth_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .pix_valid (pix_valid),
        .pix_eof   (pix.end_of_frame),
        .pix_stall (pix_stall),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .stat      (stat),
        .cmd       (cmd)
    );

    cth_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .pix       (pix),
        .cmd       (cmd),
        .stat      (stat),
        .res       (res)
    );

    // After a frame end is taken, the pixel side stalls in the next cycle while dividing
    `CTH_ASSERT_NXT(a_eof_busy, pix_valid && !pix_stall && pix.end_of_frame, pix_stall, "pixel taken while dividing")

    // Mask, hit and paint agree
    `CTH_ASSERT_IMP(a_hit_fields, res_valid, (res.hit == (res.mask == MASK_ON)) && (res.hit || (res.paint_out == '0)) && (res.hit || (res.mask == '0)), "inconsistent hit fields")

    // Frame fields stay zero on ordinary pixels
    `CTH_ASSERT_IMP(a_frame_zero, res_valid && !res.frame_done, (res.hit_total == '0) && (res.centroid_x == '0) && (res.centroid_y == '0), "frame fields set on ordinary pixel")

    // Empty frame reports minus one for both axes
    `CTH_ASSERT_IMP(a_empty_frame, res_valid && res.frame_done && (res.hit_total == '0), (res.centroid_x == '1) && (res.centroid_y == '1), "empty frame centroid not minus one")

endmodule

`default_nettype wire

/* rtl/cth_datapath.sv */
// ----------------------------------------------------------------------------
// cth_datapath
// Configuration registers, range match, hit accumulators, shared restoring
// divider for both centroid axes and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module cth_datapath
    import cth_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    input  wire cth_pix_t              pix,
    input  wire cth_cmd_t              cmd,
    output cth_stat_t                  stat,
    output cth_res_t                   res
);

    // Configuration registers
    logic [MODE_W-1:0]  mode_reg;
    logic [PIX_W-1:0]   ch1_low_reg, ch1_high_reg;
    logic [PIX_W-1:0]   ch2_low_reg, ch2_high_reg;
    logic [PIX_W-1:0]   ch3_low_reg, ch3_high_reg;
    logic [PAINT_W-1:0] paint_reg;

    // Position and accumulators
    logic [COL_W-1:0] column_reg, column_next;
    logic [ROW_W-1:0] row_reg, row_next;
    logic [CNT_W-1:0] hit_count_reg, hit_count_next;
    logic [SUM_W-1:0] sum_x_reg, sum_x_next;
    logic [SUM_W-1:0] sum_y_reg, sum_y_next;

    // Divider and pending frame result
    logic [SUM_W-1:0]   rem_x_reg, rem_y_reg, dsh_reg;
    logic [QUO_W-1:0]   quo_x_reg, quo_y_reg;
    logic [STEP_W-1:0]  step_reg;
    logic               zero_reg;
    logic [CNT_W-1:0]   total_reg;
    logic [PIX_W-1:0]   pend_mask_reg;
    logic               pend_hit_reg;
    logic [PAINT_W-1:0] pend_paint_reg;

    cth_res_t res_reg;

    logic               ch1_ok, ch2_ok, ch3_ok, match, add_en;
    logic [PIX_W-1:0]   mask_val;
    logic [PAINT_W-1:0] paint_val;
    logic               take_x, take_y;

    function automatic logic in_rng(input logic [PIX_W-1:0] v,
                                    input logic [PIX_W-1:0] lo,
                                    input logic [PIX_W-1:0] hi);
        return (v >= lo) && (v <= hi);
    endfunction

    // Write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg     <= MODE_BGR;
            ch1_low_reg  <= '0;
            ch1_high_reg <= '1;
            ch2_low_reg  <= '0;
            ch2_high_reg <= '1;
            ch3_low_reg  <= '0;
            ch3_high_reg <= '1;
            paint_reg    <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_MODE:     mode_reg     <= cfg_data[MODE_W-1:0];
                REG_CH1_LOW:  ch1_low_reg  <= cfg_data[PIX_W-1:0];
                REG_CH1_HIGH: ch1_high_reg <= cfg_data[PIX_W-1:0];
                REG_CH2_LOW:  ch2_low_reg  <= cfg_data[PIX_W-1:0];
                REG_CH2_HIGH: ch2_high_reg <= cfg_data[PIX_W-1:0];
                REG_CH3_LOW:  ch3_low_reg  <= cfg_data[PIX_W-1:0];
                REG_CH3_HIGH: ch3_high_reg <= cfg_data[PIX_W-1:0];
                REG_PAINT:    paint_reg    <= cfg_data[PAINT_W-1:0];
                default:      mode_reg     <= mode_reg;
            endcase
        end
    end

    // Test the pixel against the ranges
    always_comb
    begin
        if ((mode_reg == MODE_HSV) && (ch1_high_reg < ch1_low_reg))
        begin
            ch1_ok = (pix.chan1 <= ch1_high_reg) ||
                     ((pix.chan1 >= ch1_low_reg) && (pix.chan1 <= HUE_TOP));
        end
        else
        begin
            ch1_ok = in_rng(pix.chan1, ch1_low_reg, ch1_high_reg);
        end
        ch2_ok = in_rng(pix.chan2, ch2_low_reg, ch2_high_reg);
        ch3_ok = in_rng(pix.chan3, ch3_low_reg, ch3_high_reg);
        if (mode_reg == MODE_GRAY)
        begin
            match = in_rng(pix.chan1, ch1_low_reg, ch1_high_reg);
        end
        else
        begin
            match = ch1_ok && ch2_ok && ch3_ok;
        end
        mask_val  = match ? MASK_ON : '0;
        paint_val = match ? paint_reg : '0;
    end

    // Add the hit unless the count is saturated
    always_comb
    begin
        add_en         = match && (hit_count_reg < CNT_W'(COUNT_LIMIT));
        hit_count_next = hit_count_reg + CNT_W'(add_en);
        sum_x_next     = sum_x_reg + (add_en ? SUM_W'(column_reg) : '0);
        sum_y_next     = sum_y_reg + (add_en ? SUM_W'(row_reg) : '0);
    end

    // Advance the raster position
    always_comb
    begin
        column_next = column_reg;
        row_next    = row_reg;
        if (pix.end_of_frame)
        begin
            column_next = '0;
            row_next    = '0;
        end
        else if (pix.end_of_line)
        begin
            column_next = '0;
            if (row_reg < ROW_W'(MAX_HEIGHT - 1))
            begin
                row_next = row_reg + 1'b1;
            end
        end
        else if (column_reg < COL_W'(MAX_WIDTH - 1))
        begin
            column_next = column_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            column_reg    <= '0;
            row_reg       <= '0;
            hit_count_reg <= '0;
            sum_x_reg     <= '0;
            sum_y_reg     <= '0;
        end
        else if (cmd.accept)
        begin
            column_reg <= column_next;
            row_reg    <= row_next;
            if (pix.end_of_frame)
            begin
                hit_count_reg <= '0;
                sum_x_reg     <= '0;
                sum_y_reg     <= '0;
            end
            else
            begin
                hit_count_reg <= hit_count_next;
                sum_x_reg     <= sum_x_next;
                sum_y_reg     <= sum_y_next;
            end
        end
    end

    // Restoring divider, one quotient bit per cycle for both axes
    assign take_x = rem_x_reg >= dsh_reg;
    assign take_y = rem_y_reg >= dsh_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= '0;
        end
        else if (cmd.start_div)
        begin
            step_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            step_reg <= step_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start_div)
        begin
            rem_x_reg      <= sum_x_next;
            rem_y_reg      <= sum_y_next;
            dsh_reg        <= SUM_W'(hit_count_next) << (QUO_W - 1);
            quo_x_reg      <= '0;
            quo_y_reg      <= '0;
            zero_reg       <= (hit_count_next == '0);
            total_reg      <= hit_count_next;
            pend_mask_reg  <= mask_val;
            pend_hit_reg   <= match;
            pend_paint_reg <= paint_val;
        end
        else if (cmd.div_step)
        begin
            if (take_x)
            begin
                rem_x_reg <= rem_x_reg - dsh_reg;
            end
            if (take_y)
            begin
                rem_y_reg <= rem_y_reg - dsh_reg;
            end
            quo_x_reg <= (quo_x_reg << 1) | QUO_W'(take_x);
            quo_y_reg <= (quo_y_reg << 1) | QUO_W'(take_y);
            dsh_reg   <= dsh_reg >> 1;
        end
    end

    assign stat.div_last = (step_reg == STEP_W'(QUO_W - 1));

    // Load the result register
    always_ff @(posedge clk)
    begin
        if (cmd.load_pixel)
        begin
            res_reg.mask       <= mask_val;
            res_reg.hit        <= match;
            res_reg.paint_out  <= paint_val;
            res_reg.frame_done <= 1'b0;
            res_reg.hit_total  <= '0;
            res_reg.centroid_x <= '0;
            res_reg.centroid_y <= '0;
        end
        else if (cmd.load_frame)
        begin
            res_reg.mask       <= pend_mask_reg;
            res_reg.hit        <= pend_hit_reg;
            res_reg.paint_out  <= pend_paint_reg;
            res_reg.frame_done <= 1'b1;
            res_reg.hit_total  <= total_reg;
            res_reg.centroid_x <= zero_reg ? {CENT_W{1'b1}} : CENT_W'(quo_x_reg);
            res_reg.centroid_y <= zero_reg ? {CENT_W{1'b1}} : CENT_W'(quo_y_reg);
        end
    end

    assign res = res_reg;

endmodule

`default_nettype wire

/* rtl/cth_ctrl.sv */
// ----------------------------------------------------------------------------
// cth_ctrl
// Sequencer: takes pixels, runs the centroid division at frame end and
// keeps the result valid flag.
// ----------------------------------------------------------------------------
`default_nettype none

module cth_ctrl
    import cth_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      pix_valid,
    input  wire logic      pix_eof,
    output logic           pix_stall,
    output logic           res_valid,
    input  wire logic      res_stall,
    input  wire cth_stat_t stat,
    output cth_cmd_t       cmd
);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_DIV   = 2'd1;
    localparam logic [1:0] S_FLUSH = 2'd2;

    logic [1:0] state_reg, state_next;
    logic       res_valid_reg, res_valid_next;
    logic       out_free;

    // Result register can take new data when empty or drained this cycle
    assign out_free = !res_valid_reg || !res_stall;

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        pix_stall  = 1'b1;
        case (state_reg)
            S_IDLE:
            begin
                pix_stall = !out_free;
                if (pix_valid && out_free)
                begin
                    cmd.accept = 1'b1;
                    if (pix_eof)
                    begin
                        cmd.start_div = 1'b1;
                        state_next    = S_DIV;
                    end
                    else
                    begin
                        cmd.load_pixel = 1'b1;
                    end
                end
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                if (stat.div_last)
                begin
                    state_next = S_FLUSH;
                end
            end
            S_FLUSH:
            begin
                if (out_free)
                begin
                    cmd.load_frame = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Set on load, drop when the transaction is taken
    always_comb
    begin
        if (cmd.load_pixel || cmd.load_frame)
        begin
            res_valid_next = 1'b1;
        end
        else if (res_valid_reg && !res_stall)
        begin
            res_valid_next = 1'b0;
        end
        else
        begin
            res_valid_next = res_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            res_valid_reg <= res_valid_next;
        end
    end

    assign res_valid = res_valid_reg;

endmodule

`default_nettype wire

/* sim/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for color_threshold_centroid. A behavioral model of the
// range test, hit accumulators and frame centroid predicts every result
// transaction. The run starts with a short directed list, then sends one
// frame while the receiver holds off for a long stretch, then runs random
// frames under random configurations. Random gaps and stalls fall on both
// handshakes.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_top;

    import cth_pkg::*;

    localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;
    localparam int SETTLE      = 2 * (QUO_W + 2) + 4;
    localparam int CYCLE_LIMIT = 3_000_000;
    localparam int HOLD_PIXELS = 48;
    localparam int RANDOM_PIXELS = 680;

    typedef enum logic [1:0] {ROW_WRITE, ROW_PIXEL, ROW_PINNED} row_kind_t;

    typedef struct {
        row_kind_t                 kind;
        logic [CFG_IDX_W-1:0]      idx;
        logic [CFG_DATA_W-1:0]     val;
        cth_pix_t                  px;
        cth_res_t                  want;
    } plan_row_t;

    logic                   clk;
    logic                   rst_n;
    logic                   pix_valid;
    logic                   pix_stall;
    cth_pix_t               pix;
    logic                   res_valid;
    logic                   res_stall;
    cth_res_t               res;
    logic                   cfg_we;
    logic [CFG_IDX_W-1:0]   cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    // Model copy of the registers
    logic [MODE_W-1:0]      cur_mode;
    logic [PIX_W-1:0]       lo1, hi1, lo2, hi2, lo3, hi3;
    logic [PAINT_W-1:0]     cur_paint;

    // Model copy of position and accumulators
    logic [COL_W-1:0]       col_pos;
    logic [ROW_W-1:0]       row_pos;
    logic [CNT_W-1:0]       hit_tally;
    logic [SUM_W-1:0]       sum_col;
    logic [SUM_W-1:0]       sum_row;

    cth_res_t               pixel_outcomes[$];
    plan_row_t              plan[$];
    int                     fail_count;
    int                     cycle_count;
    bit                     hold_off_req;
    bit                     no_gaps;

    color_threshold_centroid u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .pix_valid (pix_valid),
        .pix_stall (pix_stall),
        .pix       (pix),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res       (res),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // ------------------------------------------------------------------------
    // Range test, hit accumulation and frame centroid for one pixel
    // ------------------------------------------------------------------------
    function automatic cth_res_t classify_pixel(input cth_pix_t p);
        cth_res_t         r;
        logic             first_ok;
        logic             hit;
        logic [SUM_W-1:0] mean_x;
        logic [SUM_W-1:0] mean_y;
        if (cur_mode == MODE_GRAY)
            hit = (p.chan1 >= lo1) && (p.chan1 <= hi1);
        else
        begin
            // hue wraps through zero when the bounds are reversed
            if (cur_mode == MODE_HSV && hi1 < lo1)
                first_ok = (p.chan1 <= hi1) || (p.chan1 >= lo1 && p.chan1 <= HUE_TOP);
            else
                first_ok = (p.chan1 >= lo1) && (p.chan1 <= hi1);
            hit = first_ok && (p.chan2 >= lo2) && (p.chan2 <= hi2)
                           && (p.chan3 >= lo3) && (p.chan3 <= hi3);
        end

        // accumulate until the counter saturates
        if (hit && hit_tally < COUNT_LIMIT)
        begin
            hit_tally = hit_tally + 1'b1;
            sum_col   = sum_col + col_pos;
            sum_row   = sum_row + row_pos;
        end

        r           = '0;
        r.mask      = hit ? MASK_ON : '0;
        r.hit       = hit;
        r.paint_out = hit ? cur_paint : '0;

        // close the frame, or advance the raster position
        if (p.end_of_frame)
        begin
            r.frame_done = 1'b1;
            r.hit_total  = hit_tally;
            if (hit_tally == 0)
            begin
                r.centroid_x = '1;
                r.centroid_y = '1;
            end
            else
            begin
                mean_x       = sum_col / hit_tally;
                mean_y       = sum_row / hit_tally;
                r.centroid_x = mean_x[CENT_W-1:0];
                r.centroid_y = mean_y[CENT_W-1:0];
            end
            col_pos   = '0;
            row_pos   = '0;
            hit_tally = '0;
            sum_col   = '0;
            sum_row   = '0;
        end
        else if (p.end_of_line)
        begin
            col_pos = '0;
            if (row_pos < MAX_HEIGHT - 1)
                row_pos = row_pos + 1'b1;
        end
        else if (col_pos < MAX_WIDTH - 1)
            col_pos = col_pos + 1'b1;
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Directed list builders
    // ------------------------------------------------------------------------
    function automatic plan_row_t reg_row(input logic [CFG_IDX_W-1:0] idx,
                                          input logic [CFG_DATA_W-1:0] val);
        plan_row_t r;
        r      = '{kind: ROW_WRITE, default: '0};
        r.idx  = idx;
        r.val  = val;
        return r;
    endfunction

    function automatic plan_row_t pix_row(input logic [PIX_W-1:0] c1, c2, c3,
                                          input logic eol, eof);
        plan_row_t r;
        r                 = '{kind: ROW_PIXEL, default: '0};
        r.px.chan1        = c1;
        r.px.chan2        = c2;
        r.px.chan3        = c3;
        r.px.end_of_line  = eol;
        r.px.end_of_frame = eof;
        return r;
    endfunction

    function automatic plan_row_t pinned(input plan_row_t r, input logic hit,
                                         input logic [PAINT_W-1:0] paint,
                                         input logic done,
                                         input logic [CNT_W-1:0] total,
                                         input logic [CENT_W-1:0] cx, cy);
        r.kind            = ROW_PINNED;
        r.want.mask       = hit ? MASK_ON : '0;
        r.want.hit        = hit;
        r.want.paint_out  = paint;
        r.want.frame_done = done;
        r.want.hit_total  = total;
        r.want.centroid_x = cx;
        r.want.centroid_y = cy;
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        cfg_index <= idx;
        cfg_data  <= val;
        cfg_we    <= 1'b1;
        @(posedge clk);
        cfg_we    <= 1'b0;
        // track the register with its width mask applied
        case (idx)
            REG_MODE:     cur_mode  = val[MODE_W-1:0];
            REG_CH1_LOW:  lo1       = val[PIX_W-1:0];
            REG_CH1_HIGH: hi1       = val[PIX_W-1:0];
            REG_CH2_LOW:  lo2       = val[PIX_W-1:0];
            REG_CH2_HIGH: hi2       = val[PIX_W-1:0];
            REG_CH3_LOW:  lo3       = val[PIX_W-1:0];
            REG_CH3_HIGH: hi3       = val[PIX_W-1:0];
            REG_PAINT:    cur_paint = val;
            default: ;
        endcase
        @(posedge clk);
    endtask

    // Drop valid, wait for every pending result, then let the divider settle
    task automatic drain_results();
        pix_valid <= 1'b0;
        while (pixel_outcomes.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic send_pixel(input cth_pix_t p, input bit use_want,
                              input cth_res_t want);
        int r;
        int gap;
        cth_res_t predicted;
        gap = 0;
        if (!no_gaps)
        begin
            r = $urandom_range(0, 99);
            if (r < 55)
                gap = 0;
            else if (r < 85)
                gap = $urandom_range(1, 3);
            else if (r < 97)
                gap = $urandom_range(4, 12);
            else
                gap = $urandom_range(20, 60);
        end
        if (gap > 0)
        begin
            pix_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        pix       <= p;
        pix_valid <= 1'b1;
        // hold the transaction until it is taken
        do
            @(posedge clk);
        while (pix_stall);
        predicted = classify_pixel(p);
        pixel_outcomes.push_back(use_want ? want : predicted);
    endtask

    function automatic logic [PIX_W-1:0] pick_channel(input logic [PIX_W-1:0] lo, hi);
        case ($urandom_range(0, 7))
            3:       return lo;
            4:       return hi;
            5:       return lo - 1'b1;
            6:       return hi + 1'b1;
            7:       return HUE_TOP + PIX_W'($urandom_range(0, 1));
            default: return PIX_W'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic cth_pix_t random_pixel(input logic eol, eof);
        cth_pix_t p;
        p.chan1        = pick_channel(lo1, hi1);
        p.chan2        = pick_channel(lo2, hi2);
        p.chan3        = pick_channel(lo3, hi3);
        p.end_of_line  = eol;
        p.end_of_frame = eof;
        return p;
    endfunction

    task automatic pick_bounds(input bit wrap_ok, output logic [PIX_W-1:0] lo, hi);
        case ($urandom_range(0, wrap_ok ? 4 : 3))
            0:
            begin
                lo = 8'd0;
                hi = 8'd255;
            end
            1:
            begin
                lo = PIX_W'($urandom_range(0, 200));
                hi = lo + PIX_W'($urandom_range(0, 55));
            end
            2:
            begin
                lo = PIX_W'($urandom_range(0, 255));
                hi = PIX_W'($urandom_range(lo, 255));
            end
            3:
            begin
                lo = PIX_W'($urandom_range(0, 255));
                hi = PIX_W'($urandom_range(0, 255));
            end
            default:
            begin
                lo = PIX_W'($urandom_range(120, 255));
                hi = PIX_W'($urandom_range(0, 90));
            end
        endcase
    endtask

    // ------------------------------------------------------------------------
    // Result checking
    // ------------------------------------------------------------------------
    task automatic compare_field(input string name, input logic [31:0] want, got);
        if (got !== want)
        begin
            fail_count++;
            $display("%0t ns: %s mismatch, expected %0h, got %0h",
                     $time, name, want, got);
        end
    endtask

    task automatic check_result(input cth_res_t got);
        cth_res_t want;
        if (pixel_outcomes.size() == 0)
        begin
            fail_count++;
            $display("%0t ns: result %h with no pixel pending, expected none",
                     $time, got);
        end
        else
        begin
            want = pixel_outcomes.pop_front();
            compare_field("mask",       want.mask,       got.mask);
            compare_field("hit",        want.hit,        got.hit);
            compare_field("paint_out",  want.paint_out,  got.paint_out);
            compare_field("frame_done", want.frame_done, got.frame_done);
            compare_field("hit_total",  want.hit_total,  got.hit_total);
            compare_field("centroid_x", want.centroid_x, got.centroid_x);
            compare_field("centroid_y", want.centroid_y, got.centroid_y);
        end
    endtask

    // ------------------------------------------------------------------------
    // Result side: take transactions, stall at random, one long hold-off
    // ------------------------------------------------------------------------
    initial
    begin : result_sink
        int run_left;
        int r;
        bit stalling;
        run_left  = 0;
        stalling  = 1'b0;
        res_stall = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && res_valid && !res_stall)
                check_result(res);
            if (hold_off_req)
            begin
                hold_off_req = 1'b0;
                stalling     = 1'b1;
                run_left     = 400;
            end
            else if (run_left <= 0)
            begin
                r = $urandom_range(0, 99);
                if (r < 45)
                begin
                    stalling = 1'b0;
                    run_left = $urandom_range(1, 30);
                end
                else if (r < 85)
                begin
                    stalling = 1'b1;
                    run_left = $urandom_range(1, 3);
                end
                else if (r < 97)
                begin
                    stalling = 1'b1;
                    run_left = $urandom_range(4, 20);
                end
                else
                begin
                    stalling = 1'b1;
                    run_left = $urandom_range(40, 120);
                end
            end
            run_left  = run_left - 1;
            res_stall <= stalling;
        end
    end

    // ------------------------------------------------------------------------
    // Cycle limit
    // ------------------------------------------------------------------------
    initial
    begin : watchdog
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("color_threshold_centroid verification failed");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin : stimulus
        int i;
        int row;
        int col;
        int w;
        int h;
        int n;
        int sent;
        bit is_last;
        bit eol;
        logic [PIX_W-1:0] a;
        logic [PIX_W-1:0] b;
        logic [CFG_DATA_W-1:0] word;

        rst_n        = 1'b0;
        pix_valid    = 1'b0;
        pix          = '0;
        cfg_we       = 1'b0;
        cfg_index    = REG_MODE;
        cfg_data     = '0;
        fail_count   = 0;
        hold_off_req = 1'b0;
        no_gaps      = 1'b0;
        cur_mode     = MODE_BGR;
        lo1 = 8'd0; hi1 = 8'd255;
        lo2 = 8'd0; hi2 = 8'd255;
        lo3 = 8'd0; hi3 = 8'd255;
        cur_paint    = '0;
        col_pos      = '0;
        row_pos      = '0;
        hit_tally    = '0;
        sum_col      = '0;
        sum_row      = '0;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // default ranges pass everything, paint is zero
        plan.push_back(pinned(pix_row(8'd0, 8'd0, 8'd0, 1'b0, 1'b0),
                              1'b1, 24'h0, 1'b0, 0, 0, 0));
        plan.push_back(pinned(pix_row(8'd255, 8'd255, 8'd255, 1'b0, 1'b1),
                              1'b1, 24'h0, 1'b1, 2, 0, 0));

        // plain ranges; upper data bits must be dropped
        plan.push_back(reg_row(REG_MODE, {22'h3FFFFF, MODE_BGR}));
        plan.push_back(reg_row(REG_CH1_LOW, 24'hABCD0A));
        plan.push_back(reg_row(REG_CH1_HIGH, 24'd20));
        plan.push_back(reg_row(REG_CH2_LOW, 24'd30));
        plan.push_back(reg_row(REG_CH2_HIGH, 24'd40));
        plan.push_back(reg_row(REG_CH3_LOW, 24'd50));
        plan.push_back(reg_row(REG_CH3_HIGH, 24'd60));
        plan.push_back(reg_row(REG_PAINT, 24'hABCDEF));
        plan.push_back(pinned(pix_row(8'd10, 8'd30, 8'd50, 1'b0, 1'b0),
                              1'b1, 24'hABCDEF, 1'b0, 0, 0, 0));
        plan.push_back(pinned(pix_row(8'd20, 8'd40, 8'd60, 1'b0, 1'b0),
                              1'b1, 24'hABCDEF, 1'b0, 0, 0, 0));
        plan.push_back(pinned(pix_row(8'd9, 8'd30, 8'd50, 1'b0, 1'b0),
                              1'b0, 24'h0, 1'b0, 0, 0, 0));
        plan.push_back(pix_row(8'd21, 8'd40, 8'd60, 1'b0, 1'b0));
        plan.push_back(pix_row(8'd10, 8'd29, 8'd50, 1'b1, 1'b0));
        plan.push_back(pix_row(8'd10, 8'd41, 8'd61, 1'b0, 1'b0));
        plan.push_back(pix_row(8'd15, 8'd35, 8'd55, 1'b0, 1'b1));
        // frame without hits reports -1,-1
        plan.push_back(pinned(pix_row(8'd0, 8'd0, 8'd0, 1'b0, 1'b1),
                              1'b0, 24'h0, 1'b1, 0, 12'hFFF, 12'hFFF));

        // hue wrap: low above high, capped at the hue top
        plan.push_back(reg_row(REG_MODE, {22'h0, MODE_HSV}));
        plan.push_back(reg_row(REG_CH1_LOW, 24'd170));
        plan.push_back(reg_row(REG_CH1_HIGH, 24'd10));
        plan.push_back(reg_row(REG_CH2_LOW, 24'd0));
        plan.push_back(reg_row(REG_CH2_HIGH, 24'd255));
        plan.push_back(reg_row(REG_CH3_LOW, 24'd0));
        plan.push_back(reg_row(REG_CH3_HIGH, 24'd255));
        plan.push_back(reg_row(REG_PAINT, 24'h123456));
        plan.push_back(pix_row(8'd5, 8'd0, 8'd255, 1'b0, 1'b0));
        plan.push_back(pix_row(8'd180, 8'd128, 8'd128, 1'b0, 1'b0));
        plan.push_back(pix_row(8'd181, 8'd128, 8'd128, 1'b0, 1'b0));
        plan.push_back(pix_row(8'd170, 8'd1, 8'd2, 1'b0, 1'b0));
        plan.push_back(pix_row(8'd169, 8'd1, 8'd2, 1'b1, 1'b0));
        plan.push_back(pix_row(8'd10, 8'd3, 8'd4, 1'b0, 1'b0));
        plan.push_back(pix_row(8'd11, 8'd3, 8'd4, 1'b0, 1'b0));
        // both marks: end of frame wins
        plan.push_back(pix_row(8'd255, 8'd255, 8'd0, 1'b1, 1'b1));

        // hue without wrap has no top limit
        plan.push_back(reg_row(REG_CH1_LOW, 24'd190));
        plan.push_back(reg_row(REG_CH1_HIGH, 24'd250));
        plan.push_back(pix_row(8'd200, 8'd7, 8'd7, 1'b0, 1'b0));
        plan.push_back(pix_row(8'd251, 8'd7, 8'd7, 1'b0, 1'b1));

        // gray ignores channels two and three, even an empty range
        plan.push_back(reg_row(REG_MODE, {22'h0, MODE_GRAY}));
        plan.push_back(reg_row(REG_CH1_LOW, 24'd100));
        plan.push_back(reg_row(REG_CH1_HIGH, 24'd100));
        plan.push_back(reg_row(REG_CH2_LOW, 24'd200));
        plan.push_back(reg_row(REG_CH2_HIGH, 24'd100));
        plan.push_back(reg_row(REG_PAINT, 24'hFFFFFF));
        plan.push_back(pinned(pix_row(8'd100, 8'd0, 8'd255, 1'b0, 1'b0),
                              1'b1, 24'hFFFFFF, 1'b0, 0, 0, 0));
        plan.push_back(pix_row(8'd99, 8'd200, 8'd100, 1'b0, 1'b1));

        // spare mode acts as plain ranges: reversed bounds match nothing
        plan.push_back(reg_row(REG_MODE, {22'h3FFFFF, MODE_SPARE}));
        plan.push_back(reg_row(REG_CH1_LOW, 24'd20));
        plan.push_back(reg_row(REG_CH1_HIGH, 24'd10));
        plan.push_back(reg_row(REG_CH2_LOW, 24'd0));
        plan.push_back(reg_row(REG_CH2_HIGH, 24'd255));
        plan.push_back(pix_row(8'd5, 8'd0, 8'd0, 1'b0, 1'b0));
        plan.push_back(pinned(pix_row(8'd25, 8'd150, 8'd0, 1'b0, 1'b1),
                              1'b0, 24'h0, 1'b1, 0, 12'hFFF, 12'hFFF));

        // walk the directed list
        foreach (plan[k])
        begin
            if (plan[k].kind == ROW_WRITE)
            begin
                drain_results();
                write_reg(plan[k].idx, plan[k].val);
            end
            else
                send_pixel(plan[k].px, plan[k].kind == ROW_PINNED, plan[k].want);
        end

        // one frame of short rows while the receiver holds off
        drain_results();
        write_reg(REG_MODE, {22'h0, MODE_BGR});
        write_reg(REG_CH1_LOW, 24'd0);
        write_reg(REG_CH1_HIGH, 24'd127);
        write_reg(REG_CH2_LOW, 24'd0);
        write_reg(REG_CH2_HIGH, 24'd255);
        write_reg(REG_CH3_LOW, 24'd0);
        write_reg(REG_CH3_HIGH, 24'd255);
        write_reg(REG_PAINT, 24'h00FF00);
        // receiver holds off while pixels keep coming
        hold_off_req = 1'b1;
        for (i = 0; i < HOLD_PIXELS; i++)
            send_pixel(random_pixel((i % 8) == 7, i == HOLD_PIXELS - 1), 1'b0, '0);

        // random frames under random configurations
        sent = 0;
        while (sent < RANDOM_PIXELS)
        begin
            if ($urandom_range(0, 2) == 0)
            begin
                drain_results();
                word = CFG_DATA_W'($urandom);
                word[MODE_W-1:0] = MODE_W'($urandom_range(0, 3));
                write_reg(REG_MODE, word);
                pick_bounds(1'b1, a, b);
                word = CFG_DATA_W'($urandom); word[PIX_W-1:0] = a;
                write_reg(REG_CH1_LOW, word);
                word = CFG_DATA_W'($urandom); word[PIX_W-1:0] = b;
                write_reg(REG_CH1_HIGH, word);
                pick_bounds(1'b0, a, b);
                word = CFG_DATA_W'($urandom); word[PIX_W-1:0] = a;
                write_reg(REG_CH2_LOW, word);
                word = CFG_DATA_W'($urandom); word[PIX_W-1:0] = b;
                write_reg(REG_CH2_HIGH, word);
                pick_bounds(1'b0, a, b);
                word = CFG_DATA_W'($urandom); word[PIX_W-1:0] = a;
                write_reg(REG_CH3_LOW, word);
                word = CFG_DATA_W'($urandom); word[PIX_W-1:0] = b;
                write_reg(REG_CH3_HIGH, word);
                case ($urandom_range(0, 5))
                    0:       write_reg(REG_PAINT, 24'h000000);
                    1:       write_reg(REG_PAINT, 24'hFFFFFF);
                    default: write_reg(REG_PAINT, CFG_DATA_W'($urandom));
                endcase
            end
            no_gaps = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 99) < 85)
            begin
                // well-formed frame of random shape
                w = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60)
                                                : $urandom_range(1, 8);
                h = $urandom_range(1, 6);
                for (row = 0; row < h; row++)
                begin
                    for (col = 0; col < w; col++)
                    begin
                        is_last = (row == h - 1) && (col == w - 1);
                        eol     = (col == w - 1) && (!is_last || $urandom_range(0, 1));
                        // occasionally pause until the block is empty
                        if ($urandom_range(0, 79) == 0)
                            drain_results();
                        send_pixel(random_pixel(eol, is_last), 1'b0, '0);
                        sent++;
                    end
                end
            end
            else
            begin
                // loose marks, frames may be cut short or run on
                n = $urandom_range(1, 25);
                for (i = 0; i < n; i++)
                begin
                    send_pixel(random_pixel($urandom_range(0, 3) == 0,
                                            $urandom_range(0, 11) == 0), 1'b0, '0);
                    sent++;
                end
            end
        end
        no_gaps = 1'b0;

        drain_results();
        if (fail_count == 0)
            $display("color_threshold_centroid verification clean");
        else
            $display("color_threshold_centroid verification failed");
        $finish;
    end

endmodule
